>>> src/tcs_pkg.sv
// shared constants, types and the sequencer program for the touch calibration block
`default_nettype none

package tcs_pkg;

  localparam int FIELD_W     = 10;
  localparam int CNT_W       = 8;
  localparam int MAX_SAMPLES = 5;
  localparam int SUM_W       = FIELD_W + $clog2(MAX_SAMPLES);
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = 2 * FIELD_W;
  localparam int QUOT_W      = FIELD_W + 1;
  localparam int QCNT_W      = $clog2(QUOT_W + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int PC_W        = 4;

  localparam int DEF_SAMPLES_PER_AXIS = 5;
  localparam int DEF_ADC_BITS         = 10;

  localparam logic [FIELD_W-1:0] WIDTH_RST     = FIELD_W'(320);
  localparam logic [FIELD_W-1:0] HEIGHT_RST    = FIELD_W'(240);
  localparam logic [CNT_W-1:0]   CAL_TOUCH_RST = CNT_W'(8);
  localparam logic [FIELD_W-1:0] UPPER_RST     = '0;
  localparam logic [FIELD_W-1:0] LOWER_RST     = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_CAL_TOUCHES   = 2'd2
  } tcs_reg_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_AVG,
    OP_BOUNDS,
    OP_MUL,
    OP_DIV,
    OP_WAIT,
    OP_STORE,
    OP_EMIT
  } tcs_op_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_NO_BEAT,
    COND_DIV_BUSY,
    COND_OUT_HELD
  } tcs_cond_t;

  typedef struct packed {
    tcs_op_t         op;
    logic            axis_y;
    tcs_cond_t       cond;
    logic [PC_W-1:0] target;
  } tcs_ucode_t;

  typedef struct packed {
    logic busy;
    logic ovf;
  } tcs_div_stat_t;

  localparam logic [PC_W-1:0] STEP_IDLE   = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_WAIT_X = PC_W'(5);
  localparam logic [PC_W-1:0] STEP_WAIT_Y = PC_W'(9);
  localparam logic [PC_W-1:0] STEP_EMIT   = PC_W'(11);
  localparam logic [PC_W-1:0] PROG_LAST   = STEP_EMIT;

  // one control word per step; a taken condition jumps to target, else the next step (the last step wraps to the first)
  function automatic tcs_ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    tcs_ucode_t w;
    w = '{op: OP_WAIT, axis_y: 1'b0, cond: COND_NONE, target: STEP_IDLE};
    case (pc)
      PC_W'(0):  w = '{op: OP_IDLE,   axis_y: 1'b0, cond: COND_NO_BEAT,  target: STEP_IDLE};
      PC_W'(1):  w = '{op: OP_AVG,    axis_y: 1'b0, cond: COND_NONE,     target: STEP_IDLE};
      PC_W'(2):  w = '{op: OP_BOUNDS, axis_y: 1'b0, cond: COND_NONE,     target: STEP_IDLE};
      PC_W'(3):  w = '{op: OP_MUL,    axis_y: 1'b0, cond: COND_NONE,     target: STEP_IDLE};
      PC_W'(4):  w = '{op: OP_DIV,    axis_y: 1'b0, cond: COND_NONE,     target: STEP_IDLE};
      PC_W'(5):  w = '{op: OP_WAIT,   axis_y: 1'b0, cond: COND_DIV_BUSY, target: STEP_WAIT_X};
      PC_W'(6):  w = '{op: OP_STORE,  axis_y: 1'b0, cond: COND_NONE,     target: STEP_IDLE};
      PC_W'(7):  w = '{op: OP_MUL,    axis_y: 1'b1, cond: COND_NONE,     target: STEP_IDLE};
      PC_W'(8):  w = '{op: OP_DIV,    axis_y: 1'b1, cond: COND_NONE,     target: STEP_IDLE};
      PC_W'(9):  w = '{op: OP_WAIT,   axis_y: 1'b1, cond: COND_DIV_BUSY, target: STEP_WAIT_Y};
      PC_W'(10): w = '{op: OP_STORE,  axis_y: 1'b1, cond: COND_NONE,     target: STEP_IDLE};
      PC_W'(11): w = '{op: OP_EMIT,   axis_y: 1'b0, cond: COND_OUT_HELD, target: STEP_EMIT};
      default:   w = '{op: OP_WAIT,   axis_y: 1'b0, cond: COND_NONE,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> src/tcs_touch_if.sv
// touch sample channel: ten adc samples per beat
`default_nettype none

interface tcs_touch_if import tcs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] x_sample_0;
  logic [FIELD_W-1:0] x_sample_1;
  logic [FIELD_W-1:0] x_sample_2;
  logic [FIELD_W-1:0] x_sample_3;
  logic [FIELD_W-1:0] x_sample_4;
  logic [FIELD_W-1:0] y_sample_0;
  logic [FIELD_W-1:0] y_sample_1;
  logic [FIELD_W-1:0] y_sample_2;
  logic [FIELD_W-1:0] y_sample_3;
  logic [FIELD_W-1:0] y_sample_4;

  modport source (
    output valid, x_sample_0, x_sample_1, x_sample_2, x_sample_3, x_sample_4,
    output y_sample_0, y_sample_1, y_sample_2, y_sample_3, y_sample_4,
    input  ready
  );
  modport sink (
    input  valid, x_sample_0, x_sample_1, x_sample_2, x_sample_3, x_sample_4,
    input  y_sample_0, y_sample_1, y_sample_2, y_sample_3, y_sample_4,
    output ready
  );
endinterface

`default_nettype wire

>>> src/tcs_result_if.sv
// result channel: averaged and scaled touch position
`default_nettype none

interface tcs_result_if import tcs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] avg_x;
  logic [FIELD_W-1:0] avg_y;
  logic               touch_accepted;
  logic               calibrating;
  logic [FIELD_W-1:0] screen_x;
  logic [FIELD_W-1:0] screen_y;
  logic               span_fault;

  modport source (
    output valid, avg_x, avg_y, touch_accepted, calibrating, screen_x, screen_y, span_fault,
    input  ready
  );
  modport sink (
    input  valid, avg_x, avg_y, touch_accepted, calibrating, screen_x, screen_y, span_fault,
    output ready
  );
endinterface

`default_nettype wire

>>> src/tcs_cfg_if.sv
// configuration write channel
`default_nettype none

interface tcs_cfg_if import tcs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FIELD_W-1:0]   wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

>>> src/tcs_div.sv
// shared restoring divider, one quotient bit per cycle, with early saturation detect
`default_nettype none

module tcs_div import tcs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [PROD_W-1:0]  dividend,
  input  logic [FIELD_W-1:0] divisor,
  output logic [QUOT_W-1:0]  quot,
  output tcs_div_stat_t      stat
);

  logic [FIELD_W-1:0] rem;
  logic [QUOT_W-1:0]  acc;
  logic [FIELD_W-1:0] dvsr;
  logic [QCNT_W-1:0]  cnt;
  logic               busy;
  logic               ovf;

  logic [FIELD_W-1:0] high;
  logic               ovf_now;
  logic [FIELD_W:0]   trial;
  logic [FIELD_W:0]   diff;
  logic               ge;

  // quotient would not fit in QUOT_W bits: caller saturates anyway
  assign high    = FIELD_W'(dividend[PROD_W-1:QUOT_W]);
  assign ovf_now = high >= divisor;

  assign trial = {rem, acc[QUOT_W-1]};
  assign diff  = trial - {1'b0, dvsr};
  assign ge    = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ovf  <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      rem  <= high;
      acc  <= dividend[QUOT_W-1:0];
      dvsr <= divisor;
      ovf  <= ovf_now;
      busy <= !ovf_now;
      cnt  <= QCNT_W'(QUOT_W);
    end else if (busy) begin
      rem <= ge ? diff[FIELD_W-1:0] : trial[FIELD_W-1:0];
      acc <= {acc[QUOT_W-2:0], ge};
      cnt <= cnt - QCNT_W'(1);
      if (cnt == QCNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quot = acc;
  assign stat = '{busy: busy, ovf: ovf};

endmodule

`default_nettype wire

>>> src/touch_calibrate_and_scale.sv
// top level: touch averaging, bound learning and screen scaling under microcode control
`default_nettype none

// Each accepted beat carries up to five x and five y adc samples. The block averages
// each axis, learns the x and y minimum and maximum over the first calibration_touches
// touches (always accepted), then accepts a touch only inside the learned bounds, and
// scales x from the minimum and inverted y from the maximum to the configured screen
// size, saturating to 0..size; an axis with no positive span gives 0 and span_fault.
// A touch steps from the accepting beat through averaging, bounds, and for x and then y
// the multiply, divide, wait and store steps, to the output step that loads the result;
// the sequencer then returns to idle to take the next touch. The shared 11-step divider
// is run once per axis and the wait step holds while it is busy (an axis whose quotient
// is known to saturate does not start it, so its wait step does not hold).
// A result waiting in the output register does not hold off the next beat; the touch
// after it waits at the output step until the register is free. Configuration writes
// are taken at any time.
module touch_calibrate_and_scale import tcs_pkg::*; #(
  parameter int SAMPLES_PER_AXIS = DEF_SAMPLES_PER_AXIS,
  parameter int ADC_BITS         = DEF_ADC_BITS
) (
  input  logic            clk,
  input  logic            rst,
  tcs_touch_if.sink       touch_in,
  tcs_result_if.source    result,
  tcs_cfg_if.sink         cfg
);

  localparam int unsigned        ADC_MASK_INT = (1 << ADC_BITS) - 1;
  localparam logic [FIELD_W-1:0] SAMPLE_MASK  = FIELD_W'(ADC_MASK_INT);
  localparam int unsigned        RECIP_INT    =
      ((1 << RECIP_SHIFT) + SAMPLES_PER_AXIS - 1) / SAMPLES_PER_AXIS;
  localparam logic [RECIP_W-1:0] RECIP        = RECIP_W'(RECIP_INT);
  localparam int                 MEAN_W       = SUM_W + RECIP_W;

  // sequencer
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  tcs_ucode_t      uc;
  logic            take;

  // configuration
  logic [FIELD_W-1:0] screen_width;
  logic [FIELD_W-1:0] screen_height;
  logic [CNT_W-1:0]   cal_touches;

  // learned state
  logic [FIELD_W-1:0] x_upper;
  logic [FIELD_W-1:0] x_lower;
  logic [FIELD_W-1:0] y_upper;
  logic [FIELD_W-1:0] y_lower;
  logic [CNT_W-1:0]   touches_seen;

  // datapath
  logic [FIELD_W-1:0] x_smp [MAX_SAMPLES];
  logic [FIELD_W-1:0] y_smp [MAX_SAMPLES];
  logic [SUM_W-1:0]   x_sum;
  logic [SUM_W-1:0]   y_sum;
  logic [SUM_W-1:0]   x_sum_r;
  logic [SUM_W-1:0]   y_sum_r;
  logic [MEAN_W-1:0]  x_mean_full;
  logic [MEAN_W-1:0]  y_mean_full;
  logic [FIELD_W-1:0] ax;
  logic [FIELD_W-1:0] ay;
  logic               cal;
  logic               cal_now;
  logic               acc;
  logic               fault;
  logic               zero_ax;
  logic [PROD_W-1:0]  prod;
  logic [FIELD_W-1:0] span;
  logic [FIELD_W-1:0] sx;
  logic [FIELD_W-1:0] sy;

  // per-axis selection for the shared multiply and divide
  logic [FIELD_W-1:0] size_sel;
  logic               fault_sel;
  logic               zero_sel;
  logic [FIELD_W-1:0] dist_sel;
  logic [FIELD_W-1:0] span_sel;
  logic [FIELD_W-1:0] scaled;

  // divider
  logic [QUOT_W-1:0]  quot;
  tcs_div_stat_t      div_stat;

  // output register
  logic               res_valid;
  logic               out_free;
  logic               in_beat;

  assign uc      = ucode_rom(pc);
  assign in_beat = touch_in.valid && touch_in.ready;
  assign out_free = !res_valid || result.ready;

  assign touch_in.ready = (uc.op == OP_IDLE);
  assign cfg.ready      = 1'b1;

  always_comb begin
    case (uc.cond)
      COND_NONE:     take = 1'b0;
      COND_NO_BEAT:  take = !in_beat;
      COND_DIV_BUSY: take = div_stat.busy;
      COND_OUT_HELD: take = !out_free;
      default:       take = 1'b0;
    endcase
    if (take) begin
      pc_next = uc.target;
    end else if (pc == PROG_LAST) begin
      pc_next = STEP_IDLE;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  assign x_smp[0] = touch_in.x_sample_0;
  assign x_smp[1] = touch_in.x_sample_1;
  assign x_smp[2] = touch_in.x_sample_2;
  assign x_smp[3] = touch_in.x_sample_3;
  assign x_smp[4] = touch_in.x_sample_4;
  assign y_smp[0] = touch_in.y_sample_0;
  assign y_smp[1] = touch_in.y_sample_1;
  assign y_smp[2] = touch_in.y_sample_2;
  assign y_smp[3] = touch_in.y_sample_3;
  assign y_smp[4] = touch_in.y_sample_4;

  always_comb begin
    x_sum = '0;
    y_sum = '0;
    for (int i = 0; i < SAMPLES_PER_AXIS; i++) begin
      x_sum = x_sum + SUM_W'(x_smp[i] & SAMPLE_MASK);
      y_sum = y_sum + SUM_W'(y_smp[i] & SAMPLE_MASK);
    end
  end

  // divide by the sample count as multiply by a rounded-up reciprocal
  assign x_mean_full = MEAN_W'(x_sum_r) * MEAN_W'(RECIP);
  assign y_mean_full = MEAN_W'(y_sum_r) * MEAN_W'(RECIP);

  assign cal_now = touches_seen < cal_touches;

  always_comb begin
    if (uc.axis_y) begin
      size_sel  = screen_height;
      fault_sel = y_upper <= y_lower;
      zero_sel  = fault_sel || (ay >= y_upper);
      dist_sel  = y_upper - ay;
      span_sel  = y_upper - y_lower;
    end else begin
      size_sel  = screen_width;
      fault_sel = x_upper <= x_lower;
      zero_sel  = fault_sel || (ax <= x_lower);
      dist_sel  = ax - x_lower;
      span_sel  = x_upper - x_lower;
    end
  end

  always_comb begin
    if (zero_ax) begin
      scaled = '0;
    end else if (div_stat.ovf || (quot > QUOT_W'(size_sel))) begin
      scaled = size_sel;
    end else begin
      scaled = quot[FIELD_W-1:0];
    end
  end

  tcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (uc.op == OP_DIV),
    .dividend (prod),
    .divisor  (span),
    .quot     (quot),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc            <= STEP_IDLE;
      screen_width  <= WIDTH_RST;
      screen_height <= HEIGHT_RST;
      cal_touches   <= CAL_TOUCH_RST;
      x_upper       <= UPPER_RST;
      x_lower       <= LOWER_RST;
      y_upper       <= UPPER_RST;
      y_lower       <= LOWER_RST;
      touches_seen  <= '0;
      res_valid     <= 1'b0;
    end else begin
      pc <= pc_next;

      // the output step reloads the register itself when the held beat leaves
      if (res_valid && result.ready && (uc.op != OP_EMIT)) begin
        res_valid <= 1'b0;
      end

      if (cfg.valid) begin
        case (cfg.index)
          REG_SCREEN_WIDTH:  screen_width  <= cfg.wdata;
          REG_SCREEN_HEIGHT: screen_height <= cfg.wdata;
          REG_CAL_TOUCHES:   cal_touches   <= cfg.wdata[CNT_W-1:0];
          default: ;
        endcase
      end

      case (uc.op)
        OP_IDLE: begin
          if (in_beat) begin
            x_sum_r <= x_sum;
            y_sum_r <= y_sum;
          end
        end
        OP_AVG: begin
          ax <= x_mean_full[RECIP_SHIFT +: FIELD_W];
          ay <= y_mean_full[RECIP_SHIFT +: FIELD_W];
        end
        OP_BOUNDS: begin
          cal   <= cal_now;
          fault <= 1'b0;
          if (cal_now) begin
            // minimum and maximum move independently
            if (ax > x_upper) x_upper <= ax;
            if (ax < x_lower) x_lower <= ax;
            if (ay > y_upper) y_upper <= ay;
            if (ay < y_lower) y_lower <= ay;
            touches_seen <= touches_seen + CNT_W'(1);
            acc          <= 1'b1;
          end else begin
            acc <= (ax >= x_lower) && (ax <= x_upper) && (ay >= y_lower) && (ay <= y_upper);
          end
        end
        OP_MUL: begin
          prod    <= PROD_W'(size_sel) * PROD_W'(dist_sel);
          span    <= span_sel;
          zero_ax <= zero_sel;
          if (fault_sel) begin
            fault <= 1'b1;
          end
        end
        OP_STORE: begin
          if (uc.axis_y) begin
            sy <= scaled;
          end else begin
            sx <= scaled;
          end
        end
        OP_EMIT: begin
          if (out_free) begin
            res_valid             <= 1'b1;
            result.avg_x          <= ax;
            result.avg_y          <= ay;
            result.touch_accepted <= acc;
            result.calibrating    <= cal;
            result.screen_x       <= sx;
            result.screen_y       <= sy;
            result.span_fault     <= fault;
          end
        end
        default: ;
      endcase
    end
  end

  assign result.valid = res_valid;

endmodule

`default_nettype wire

>>> src/tcs_checker.sv
// port-level checks for the touch calibration block, bound to the top level
`default_nettype none

module tcs_checker (
  input logic          clk,
  input logic          rst,
  tcs_touch_if.sink    touch_in,
  tcs_result_if.source result,
  tcs_cfg_if.sink      cfg
);

  // a result held back by the sink keeps its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable({result.avg_x, result.avg_y,
      result.touch_accepted, result.calibrating, result.screen_x, result.screen_y,
      result.span_fault}))
    else $error("result payload changed while stalled");

  // one touch at a time: busy right after taking a beat
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    touch_in.valid && touch_in.ready |=> !touch_in.ready)
    else $error("input ready straight after an accepted beat");

  // a touch that learns bounds is always accepted
  a_cal_accepted: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.calibrating |-> result.touch_accepted)
    else $error("calibrating touch not accepted");

  // a new result is only loaded while no touch is being taken
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(!touch_in.ready))
    else $error("result appeared while the block was idle");

  // the write channel never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg.valid |-> cfg.ready)
    else $error("configuration write stalled");

endmodule

bind touch_calibrate_and_scale tcs_checker u_tcs_checker (
  .clk      (clk),
  .rst      (rst),
  .touch_in (touch_in),
  .result   (result),
  .cfg      (cfg)
);

`default_nettype wire

>>> dv/touch_calibrate_and_scale_tb.sv
// testbench for the touch calibration and scaling block: directed and random touches
`timescale 1ns / 100ps

module touch_calibrate_and_scale_tb;
  import tcs_pkg::*;

  localparam int SAMPLES      = DEF_SAMPLES_PER_AXIS;
  localparam int RANDOM_ITEMS = 1220;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int REPORT_LIMIT = 50;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [MAX_SAMPLES-1:0][FIELD_W-1:0] xs;
    logic [MAX_SAMPLES-1:0][FIELD_W-1:0] ys;
  } touch_t;

  typedef struct packed {
    logic [FIELD_W-1:0] avg_x;
    logic [FIELD_W-1:0] avg_y;
    logic               accepted;
    logic               calibrating;
    logic [FIELD_W-1:0] screen_x;
    logic [FIELD_W-1:0] screen_y;
    logic               fault;
  } position_t;

  logic clk = 1'b0;
  logic rst;

  tcs_touch_if  touch_bus ();
  tcs_result_if result_bus ();
  tcs_cfg_if    cfg_bus ();

  touch_calibrate_and_scale DUT (
    .clk      (clk),
    .rst      (rst),
    .touch_in (touch_bus),
    .result   (result_bus),
    .cfg      (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted block state and register copies
  logic [FIELD_W-1:0] x_hi         = UPPER_RST;
  logic [FIELD_W-1:0] x_lo         = LOWER_RST;
  logic [FIELD_W-1:0] y_hi         = UPPER_RST;
  logic [FIELD_W-1:0] y_lo         = LOWER_RST;
  logic [CNT_W-1:0]   touches_seen = '0;
  logic [FIELD_W-1:0] width_cfg    = WIDTH_RST;
  logic [FIELD_W-1:0] height_cfg   = HEIGHT_RST;
  logic [CNT_W-1:0]   cal_cfg      = CAL_TOUCH_RST;

  position_t expected_positions[$];
  int        mismatches   = 0;
  int        cycle_count  = 0;
  bit        tx_quiet     = 1'b0;
  bit        rx_quiet     = 1'b0;
  bit        hold_results = 1'b0;

  function automatic logic [FIELD_W-1:0] axis_mean(
    input logic [MAX_SAMPLES-1:0][FIELD_W-1:0] s
  );
    int sum;
    sum = 0;
    for (int i = 0; i < SAMPLES; i++) sum += int'(s[i]);
    return FIELD_W'(sum / SAMPLES);
  endfunction

  // averages, learns bounds while calibrating, then scales both axes
  function automatic position_t scale_touch(input touch_t t);
    position_t p;
    int ax, ay, xl, xh, yl, yh, w, h, v;
    p.avg_x = axis_mean(t.xs);
    p.avg_y = axis_mean(t.ys);
    p.calibrating = touches_seen < cal_cfg;
    if (p.calibrating) begin
      if (p.avg_x > x_hi) x_hi = p.avg_x;
      if (p.avg_x < x_lo) x_lo = p.avg_x;
      if (p.avg_y > y_hi) y_hi = p.avg_y;
      if (p.avg_y < y_lo) y_lo = p.avg_y;
      touches_seen = touches_seen + CNT_W'(1);
      p.accepted = 1'b1;
    end else begin
      p.accepted = p.avg_x >= x_lo && p.avg_x <= x_hi && p.avg_y >= y_lo && p.avg_y <= y_hi;
    end
    ax = int'(p.avg_x);  ay = int'(p.avg_y);
    xl = int'(x_lo);     xh = int'(x_hi);
    yl = int'(y_lo);     yh = int'(y_hi);
    w  = int'(width_cfg);
    h  = int'(height_cfg);
    p.fault = 1'b0;
    if (xh <= xl) begin
      p.fault = 1'b1;
      v = 0;
    end else if (ax <= xl) begin
      v = 0;
    end else begin
      v = (w * (ax - xl)) / (xh - xl);
      if (v > w) v = w;
    end
    p.screen_x = FIELD_W'(v);
    // y runs downward from the upper bound
    if (yh <= yl) begin
      p.fault = 1'b1;
      v = 0;
    end else if (ay >= yh) begin
      v = 0;
    end else begin
      v = (h * (yh - ay)) / (yh - yl);
      if (v > h) v = h;
    end
    p.screen_y = FIELD_W'(v);
    return p;
  endfunction

  function automatic touch_t cluster_touch(input int cx, input int cy, input int spread);
    touch_t t;
    int v;
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      v = cx + int'($urandom_range(0, 2 * spread)) - spread;
      t.xs[i] = FIELD_W'((v < 0) ? 0 : (v > 1023) ? 1023 : v);
      v = cy + int'($urandom_range(0, 2 * spread)) - spread;
      t.ys[i] = FIELD_W'((v < 0) ? 0 : (v > 1023) ? 1023 : v);
    end
    return t;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(16, 60);
  endfunction

  function automatic int tx_gap();
    if (tx_quiet || $urandom_range(0, 99) < 55) return 0;
    return idle_len();
  endfunction

  // aims mostly at the bounds, just past them, or inside
  function automatic int pick_coord(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 99);
    if (hi < lo || r >= 85) return $urandom_range(0, 1023);
    if (r < 40) return $urandom_range(lo, hi);
    if (r < 60) return ($urandom_range(0, 1) != 0) ? hi : lo;
    if ($urandom_range(0, 1) != 0) return hi + int'($urandom_range(1, 20));
    return lo - int'($urandom_range(1, 20));
  endfunction

  function automatic touch_t random_touch();
    touch_t t;
    if ($urandom_range(0, 99) < 15) begin
      for (int i = 0; i < MAX_SAMPLES; i++) begin
        t.xs[i] = FIELD_W'($urandom_range(0, 1023));
        t.ys[i] = FIELD_W'($urandom_range(0, 1023));
      end
    end else if (touches_seen < cal_cfg) begin
      t = cluster_touch($urandom_range(120, 900), $urandom_range(120, 900),
                        $urandom_range(0, 6));
    end else begin
      t = cluster_touch(pick_coord(x_lo, x_hi), pick_coord(y_lo, y_hi),
                        ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 4));
    end
    return t;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 15) return FIELD_W'(1);
    if (r < 25) return FIELD_W'(1023);
    return FIELD_W'($urandom_range(1, 1023));
  endfunction

  function automatic logic [FIELD_W-1:0] pick_cal();
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 10) n = 0;
    else if (r < 15) n = 255;
    else if (r < 80) n = int'(touches_seen) + int'($urandom_range(1, 6));
    else n = $urandom_range(0, 255);
    if (n > 255) n = 255;
    // bits above the counter width must be dropped
    return FIELD_W'(n) | FIELD_W'($urandom_range(0, 3) << CNT_W);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
  endtask

  task automatic send_touch(input touch_t t, input int gap);
    if (gap > 0) begin
      touch_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    touch_bus.valid      <= 1'b1;
    touch_bus.x_sample_0 <= t.xs[0];
    touch_bus.x_sample_1 <= t.xs[1];
    touch_bus.x_sample_2 <= t.xs[2];
    touch_bus.x_sample_3 <= t.xs[3];
    touch_bus.x_sample_4 <= t.xs[4];
    touch_bus.y_sample_0 <= t.ys[0];
    touch_bus.y_sample_1 <= t.ys[1];
    touch_bus.y_sample_2 <= t.ys[2];
    touch_bus.y_sample_3 <= t.ys[3];
    touch_bus.y_sample_4 <= t.ys[4];
    do @(posedge clk); while (!touch_bus.ready);
    expected_positions.push_back(scale_touch(t));
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.wdata <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_SCREEN_WIDTH:  width_cfg  = val;
      REG_SCREEN_HEIGHT: height_cfg = val;
      REG_CAL_TOUCHES:   cal_cfg    = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_idle();
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic drain_results();
    touch_bus.valid <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
  endtask

  // no calibration at all: bounds stay at their reset values
  task automatic test_unlearned_bounds();
    cfg_write(REG_CAL_TOUCHES, '0);
    cfg_write(REG_SPARE, 10'h3ff);
    cfg_idle();
    send_touch(cluster_touch(0, 0, 0), 0);
    send_touch(cluster_touch(1023, 1023, 0), tx_gap());
    drain_results();
  endtask

  task automatic test_calibration_learning();
    touch_t t;
    cfg_write(REG_CAL_TOUCHES, 10'h104);
    cfg_idle();
    // first touch leaves both spans at zero
    send_touch(cluster_touch(500, 500, 0), 0);
    t.xs = {10'd304, 10'd303, 10'd302, 10'd301, 10'd300};
    t.ys = {10'd704, 10'd700, 10'd700, 10'd700, 10'd700};
    send_touch(t, 0);
    t.xs = {10'd800, 10'd801, 10'd801, 10'd801, 10'd801};
    t.ys = {10'd250, 10'd250, 10'd250, 10'd250, 10'd250};
    send_touch(t, tx_gap());
    drain_results();
    // lowering the count below the touches already used ends calibration
    cfg_write(REG_CAL_TOUCHES, 10'd2);
    cfg_idle();
    send_touch(cluster_touch(600, 400, 0), 0);
    drain_results();
  endtask

  task automatic test_bounds_and_saturation();
    touch_t t;
    send_touch(cluster_touch(302, 700, 0), 0);
    send_touch(cluster_touch(800, 250, 0), 0);
    send_touch(cluster_touch(301, 701, 0), tx_gap());
    send_touch(cluster_touch(801, 249, 0), 0);
    send_touch(cluster_touch(1023, 0, 0), tx_gap());
    send_touch(cluster_touch(0, 1023, 0), 0);
    t.xs = {10'h3ff, 10'h2aa, 10'h155, 10'h2aa, 10'h155};
    t.ys = {10'h000, 10'h155, 10'h2aa, 10'h155, 10'h2aa};
    send_touch(t, 0);
    drain_results();
  endtask

  task automatic test_screen_sizes();
    cfg_write(REG_SCREEN_WIDTH, '0);
    cfg_write(REG_SCREEN_HEIGHT, 10'd1023);
    cfg_idle();
    send_touch(cluster_touch(551, 475, 0), 0);
    send_touch(cluster_touch(700, 300, 2), 0);
    drain_results();
    cfg_write(REG_SCREEN_WIDTH, 10'd1023);
    cfg_write(REG_SCREEN_HEIGHT, '0);
    cfg_idle();
    send_touch(cluster_touch(551, 475, 0), 0);
    send_touch(cluster_touch(310, 690, 2), 0);
    drain_results();
    cfg_write(REG_SCREEN_WIDTH, 10'd1);
    cfg_write(REG_SCREEN_HEIGHT, 10'd1);
    cfg_idle();
    send_touch(cluster_touch(799, 251, 0), 0);
    drain_results();
    cfg_write(REG_SCREEN_WIDTH, 10'd1023);
    cfg_write(REG_SCREEN_HEIGHT, 10'd1023);
    cfg_idle();
    send_touch(cluster_touch(400, 600, 0), 0);
    drain_results();
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_output_backpressure();
    tx_quiet     = 1'b1;
    hold_results = 1'b1;
    repeat (6) send_touch(random_touch(), 0);
    drain_results();
    tx_quiet = 1'b0;
  endtask

  task automatic test_random_touches();
    int sent, n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      tx_quiet = ($urandom_range(0, 5) == 0);
      rx_quiet = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 2) != 0) begin
        cfg_write(REG_SCREEN_WIDTH, pick_size());
        cfg_write(REG_SCREEN_HEIGHT, pick_size());
      end
      if ($urandom_range(0, 2) == 0) cfg_write(REG_CAL_TOUCHES, pick_cal());
      if ($urandom_range(0, 9) == 0) cfg_write(REG_SPARE, FIELD_W'($urandom_range(0, 1023)));
      cfg_idle();
      n = $urandom_range(10, 60);
      repeat (n) send_touch(random_touch(), tx_gap());
      sent += n;
    end
    drain_results();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin : result_ready_drive
    int stall_left;
    stall_left = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        hold_results = 1'b0;
        stall_left   = 400;
      end else if (stall_left == 0 && !rx_quiet && $urandom_range(0, 99) < 15) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        result_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_result
    position_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (expected_positions.size() == 0) begin
        report_mismatch("result beat with nothing pending", 1, 0);
      end else begin
        want = expected_positions.pop_front();
        if (result_bus.avg_x !== want.avg_x)
          report_mismatch("avg_x", result_bus.avg_x, want.avg_x);
        if (result_bus.avg_y !== want.avg_y)
          report_mismatch("avg_y", result_bus.avg_y, want.avg_y);
        if (result_bus.touch_accepted !== want.accepted)
          report_mismatch("touch_accepted", result_bus.touch_accepted, want.accepted);
        if (result_bus.calibrating !== want.calibrating)
          report_mismatch("calibrating", result_bus.calibrating, want.calibrating);
        if (result_bus.screen_x !== want.screen_x)
          report_mismatch("screen_x", result_bus.screen_x, want.screen_x);
        if (result_bus.screen_y !== want.screen_y)
          report_mismatch("screen_y", result_bus.screen_y, want.screen_y);
        if (result_bus.span_fault !== want.fault)
          report_mismatch("span_fault", result_bus.span_fault, want.fault);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst                  <= 1'b1;
    touch_bus.valid      <= 1'b0;
    touch_bus.x_sample_0 <= '0;
    touch_bus.x_sample_1 <= '0;
    touch_bus.x_sample_2 <= '0;
    touch_bus.x_sample_3 <= '0;
    touch_bus.x_sample_4 <= '0;
    touch_bus.y_sample_0 <= '0;
    touch_bus.y_sample_1 <= '0;
    touch_bus.y_sample_2 <= '0;
    touch_bus.y_sample_3 <= '0;
    touch_bus.y_sample_4 <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= '0;
    cfg_bus.wdata        <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_unlearned_bounds();
    test_calibration_learning();
    test_bounds_and_saturation();
    test_screen_sizes();
    test_output_backpressure();
    test_random_touches();

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
src/tcs_pkg.sv
src/tcs_touch_if.sv
src/tcs_result_if.sv
src/tcs_cfg_if.sv
src/tcs_div.sv
src/touch_calibrate_and_scale.sv
src/tcs_checker.sv
dv/touch_calibrate_and_scale_tb.sv
